@@ sv/pdpdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdpdt_pkg
// Shared constants, types and saturation helpers of the drive distance PID.
// ----------------------------------------------------------------------------
`default_nettype none

package pdpdt_pkg;

  localparam int FracBits = 12;
  localparam int IntBand  = 100;
  localparam int PidBand  = 800;
  localparam int TrimBand = 20;
  localparam int SumMax   = 8388607;
  localparam int SumMin   = -8388608;
  localparam int SpdMax   = 1023;
  localparam int SpdMin   = -1024;

  // request kinds on tuser
  localparam logic ReqStart = 1'b0;
  localparam logic ReqTick  = 1'b1;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainP  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainI  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainD  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTrimP  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTrimI  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRamp   = 3'd6;

  // register defaults after reset
  localparam logic [15:0] GainPRst = 16'd1229;
  localparam logic [15:0] GainIRst = 16'd8;
  localparam logic [15:0] GainDRst = 16'd1229;
  localparam logic [15:0] TrimPRst = 16'd2867;
  localparam logic [15:0] TrimIRst = 16'd41;
  localparam logic [7:0]  RampRst  = 8'd5;

  // control from the distance loop to the side trim
  typedef struct packed {
    logic upd;       // tick of a running move: update trim state
    logic clr;       // start beat: clear trim state
    logic tgt_pos;   // target above zero
    logic tgt_neg;   // target below zero
  } trim_ctrl_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] s);
    logic signed [23:0] r;
    if (s > 25'(SumMax)) begin
      r = 24'(SumMax);
    end else if (s < 25'(SumMin)) begin
      r = 24'(SumMin);
    end else begin
      r = s[23:0];
    end
    return r;
  endfunction

  // Q.12 to rpm: round to nearest with ties up, then clamp to 11 bits
  function automatic logic signed [10:0] to_rpm(input logic signed [42:0] q);
    logic signed [43:0] v;
    logic signed [31:0] r;
    logic signed [10:0] o;
    v = 44'(q) + 44'sd2048;
    r = 32'(v >>> FracBits);
    if (r > 32'(SpdMax)) begin
      o = 11'(SpdMax);
    end else if (r < 32'(SpdMin)) begin
      o = 11'(SpdMin);
    end else begin
      o = r[10:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

@@ sv/pdpdt_trim.sv @@
// ----------------------------------------------------------------------------
// pdpdt_trim
// Side-to-side PI trim on the drift of absolute positions; side speeds.
// ----------------------------------------------------------------------------
`default_nettype none

module pdpdt_trim (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pdpdt_pkg::trim_ctrl_t    ctrl_i,
  input  wire logic signed [15:0]       left_position_i,
  input  wire logic signed [15:0]       right_position_i,
  input  wire logic signed [31:0]       base_speed_i,
  input  wire logic        [15:0]       trim_gain_p_i,
  input  wire logic        [15:0]       trim_gain_i_i,
  output logic signed [10:0]            left_speed_o,
  output logic signed [10:0]            right_speed_o
);

  logic signed [23:0] trim_sum_q, trim_sum_d;
  logic signed [10:0] last_left_q, last_right_q;

  logic        [16:0] left_abs, right_abs;
  logic signed [17:0] drift;
  logic        [17:0] drift_abs;
  logic signed [34:0] prod_tp;
  logic signed [40:0] prod_ti;
  logic signed [42:0] trim_term;
  logic signed [42:0] base_ext;
  logic signed [10:0] left_spd, right_spd;

  always_comb begin
    left_abs  = left_position_i[15]  ? 17'(-18'(left_position_i))  : 17'(left_position_i);
    right_abs = right_position_i[15] ? 17'(-18'(right_position_i)) : 17'(right_position_i);
    drift     = $signed({1'b0, left_abs}) - $signed({1'b0, right_abs});
    drift_abs = drift[17] ? 18'(-drift) : 18'(drift);

    trim_sum_d = trim_sum_q;
    if (drift != 18'sd0 && drift_abs < 18'(pdpdt_pkg::TrimBand)) begin
      trim_sum_d = pdpdt_pkg::sat24(25'(trim_sum_q) + 25'(drift));
    end

    prod_tp   = 35'(drift) * 35'($signed({1'b0, trim_gain_p_i}));
    prod_ti   = 41'(trim_sum_d) * 41'($signed({1'b0, trim_gain_i_i}));
    trim_term = 43'(prod_tp) + 43'(prod_ti);
    base_ext  = 43'(base_speed_i);

    if (drift == 18'sd0) begin
      left_spd  = pdpdt_pkg::to_rpm(base_ext);
      right_spd = left_spd;
    end else if (ctrl_i.tgt_pos) begin
      left_spd  = pdpdt_pkg::to_rpm(base_ext - trim_term);
      right_spd = pdpdt_pkg::to_rpm(base_ext + trim_term);
    end else if (ctrl_i.tgt_neg) begin
      left_spd  = pdpdt_pkg::to_rpm(base_ext + trim_term);
      right_spd = pdpdt_pkg::to_rpm(base_ext - trim_term);
    end else begin
      // zero target with drift: repeat the previous command
      left_spd  = last_left_q;
      right_spd = last_right_q;
    end
  end

  assign left_speed_o  = left_spd;
  assign right_speed_o = right_spd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_sum_q   <= '0;
      last_left_q  <= '0;
      last_right_q <= '0;
    end else if (ctrl_i.clr) begin
      trim_sum_q   <= '0;
      last_left_q  <= '0;
      last_right_q <= '0;
    end else if (ctrl_i.upd) begin
      trim_sum_q   <= trim_sum_d;
      last_left_q  <= left_spd;
      last_right_q <= right_spd;
    end
  end

endmodule

`default_nettype wire

@@ sv/pid_drive_position_drift_trim.sv @@
// ----------------------------------------------------------------------------
// pid_drive_position_drift_trim
// Distance PID with anti-windup band, ramp start and side trim for a drive.
// ----------------------------------------------------------------------------
// Path: the input beat lands in the input register at its accepting edge;
//   the result register loads from it once the result slot is free, so a
//   stalled result stream holds the beat in the input register.
// Throughput: one beat per cycle while the result stream does not stall; the
//   whole tick update and state loop are one pass of logic between registers.
// Reset: clears the loop state and both registers' valid flags and loads the
//   default gains, target zero and ramp step.
`default_nettype none

module pid_drive_position_drift_trim (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [15:0] left_position, [31:16] right_position
  input  wire logic        s_axis_tuser_i,   // [0] req_type
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [10:0] left_speed, [21:11] right_speed, zero pad
  output logic             m_axis_tlast_o    // move_done
);

  // configuration registers
  logic signed [15:0] tgt_q;
  logic        [15:0] gain_p_q, gain_i_q, gain_d_q, trim_p_q, trim_i_q;
  logic        [7:0]  ramp_q;

  // input register
  logic               in_vld_q;
  logic               in_req_q;
  logic signed [15:0] in_lpos_q, in_rpos_q;

  // loop state
  logic signed [16:0] prev_err_q, prev_err_d;
  logic signed [23:0] err_sum_q, err_sum_d;
  logic signed [31:0] base_q, base_d;
  logic               moving_q, moving_d;

  // result register
  logic               out_vld_q;
  logic signed [10:0] out_left_q, out_right_q, out_left_d, out_right_d;
  logic               out_last_q, out_last_d;

  logic advance, fire, in_take;
  logic tgt_pos, tgt_zero, is_tick;

  logic signed [16:0] err_raw, err_eff;
  logic        [16:0] err_abs;
  logic signed [17:0] der;
  logic signed [16:0] kd;
  logic signed [33:0] prod_p;
  logic signed [40:0] prod_i;
  logic signed [34:0] prod_d;
  logic signed [42:0] pid_sum;
  logic signed [20:0] step;
  logic signed [42:0] ramp_sum;

  pdpdt_pkg::trim_ctrl_t trim_ctrl;
  logic signed [10:0] side_left, side_right;

  function automatic logic signed [31:0] sat32(input logic signed [42:0] s);
    logic signed [31:0] r;
    if (s > 43'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -43'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // handshake: the input register moves on whenever the result slot frees
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign fire            = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q    <= '0;
      gain_p_q <= pdpdt_pkg::GainPRst;
      gain_i_q <= pdpdt_pkg::GainIRst;
      gain_d_q <= pdpdt_pkg::GainDRst;
      trim_p_q <= pdpdt_pkg::TrimPRst;
      trim_i_q <= pdpdt_pkg::TrimIRst;
      ramp_q   <= pdpdt_pkg::RampRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pdpdt_pkg::CfgTarget: tgt_q    <= cfg_wdata_i;
        pdpdt_pkg::CfgGainP:  gain_p_q <= cfg_wdata_i;
        pdpdt_pkg::CfgGainI:  gain_i_q <= cfg_wdata_i;
        pdpdt_pkg::CfgGainD:  gain_d_q <= cfg_wdata_i;
        pdpdt_pkg::CfgTrimP:  trim_p_q <= cfg_wdata_i;
        pdpdt_pkg::CfgTrimI:  trim_i_q <= cfg_wdata_i;
        pdpdt_pkg::CfgRamp:   ramp_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q  <= s_axis_tuser_i;
      in_lpos_q <= s_axis_tdata_i[15:0];
      in_rpos_q <= s_axis_tdata_i[31:16];
    end
  end

  always_comb begin
    tgt_zero = (tgt_q == 16'sd0);
    tgt_pos  = !tgt_q[15] && !tgt_zero;
    is_tick  = (in_req_q == pdpdt_pkg::ReqTick);

    err_raw = 17'(tgt_q) - 17'(in_lpos_q);
    err_abs = err_raw[16] ? 17'(-err_raw) : 17'(err_raw);

    err_eff   = err_raw;
    err_sum_d = err_sum_q;
    if (err_abs < 17'(pdpdt_pkg::IntBand) && err_raw != 17'sd0) begin
      if (!err_raw[16]) begin
        err_sum_d = pdpdt_pkg::sat24(25'(err_sum_q) + 25'(err_raw));
      end else begin
        // overshoot inside the band counts as arrival
        err_eff = '0;
      end
    end else begin
      err_sum_d = '0;
    end

    der     = 18'(err_eff) - 18'(prev_err_q);
    kd      = tgt_pos ? -$signed({1'b0, gain_d_q}) : $signed({1'b0, gain_d_q});
    prod_p  = 34'(err_eff) * 34'($signed({1'b0, gain_p_q}));
    prod_i  = 41'(err_sum_d) * 41'($signed({1'b0, gain_i_q}));
    prod_d  = 35'(der) * 35'(kd);
    pid_sum = 43'(prod_p) + 43'(prod_i) + 43'(prod_d);

    step     = $signed({1'b0, ramp_q, 12'b0});
    ramp_sum = 43'(base_q) + (tgt_pos ? 43'(step) : -43'(step));

    if (err_abs < 17'(pdpdt_pkg::PidBand)) begin
      base_d = sat32(pid_sum);
    end else begin
      base_d = sat32(ramp_sum);
    end
  end

  always_comb begin
    trim_ctrl.upd     = fire && is_tick && moving_q;
    trim_ctrl.clr     = fire && !is_tick;
    trim_ctrl.tgt_pos = tgt_pos;
    trim_ctrl.tgt_neg = tgt_q[15];
  end

  pdpdt_trim u_trim (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (trim_ctrl),
    .left_position_i  (in_lpos_q),
    .right_position_i (in_rpos_q),
    .base_speed_i     (base_d),
    .trim_gain_p_i    (trim_p_q),
    .trim_gain_i_i    (trim_i_q),
    .left_speed_o     (side_left),
    .right_speed_o    (side_right)
  );

  always_comb begin
    prev_err_d  = prev_err_q;
    moving_d    = moving_q;
    out_left_d  = '0;
    out_right_d = '0;
    out_last_d  = 1'b0;
    if (!is_tick) begin
      prev_err_d = 17'(tgt_q);
      moving_d   = !tgt_zero;
      out_last_d = tgt_zero;
    end else if (moving_q) begin
      prev_err_d = err_eff;
      if (err_eff == 17'sd0) begin
        moving_d   = 1'b0;
        out_last_d = 1'b1;
      end else begin
        out_left_d  = side_left;
        out_right_d = side_right;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      err_sum_q  <= '0;
      base_q     <= '0;
      moving_q   <= 1'b0;
    end else if (fire) begin
      if (!is_tick) begin
        prev_err_q <= prev_err_d;
        err_sum_q  <= '0;
        base_q     <= '0;
        moving_q   <= moving_d;
      end else if (moving_q) begin
        prev_err_q <= prev_err_d;
        err_sum_q  <= err_sum_d;
        base_q     <= base_d;
        moving_q   <= moving_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_left_q  <= out_left_d;
      out_right_q <= out_right_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_right_q, out_left_q};
  assign m_axis_tlast_o  = out_last_q;

  // a finished move always commands both sides to stop
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_last_q |-> out_left_q == 11'sd0 && out_right_q == 11'sd0)
    else $error("move_done with nonzero speed");

  // a tick outside a move gives a silent zero result
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_tick && !moving_q |=> out_vld_q && !out_last_q
      && out_left_q == 11'sd0 && out_right_q == 11'sd0)
    else $error("idle tick produced a command");

  // the move disarms whenever done is reported
  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_last_d |=> !moving_q)
    else $error("moving still set after done");

  // an empty result slot never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

@@ sim/pid_drive_position_drift_trim_test.sv @@
// ----------------------------------------------------------------------------
// pid_drive_position_drift_trim_test
// Self-checking bench for the drive distance PID. A directed table covers the
// idle, start, overshoot, done and saturation corners. Random moves with noise
// beats and changing gains follow. Each result beat is checked against a pin or
// a cycle-free model of the control law, with random gaps on both streams.
// ----------------------------------------------------------------------------

module pid_drive_position_drift_trim_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ReqStart = pdpdt_pkg::ReqStart;
  localparam logic ReqTick  = pdpdt_pkg::ReqTick;

  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgTarget = pdpdt_pkg::CfgTarget;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgGainP  = pdpdt_pkg::CfgGainP;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgGainI  = pdpdt_pkg::CfgGainI;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgGainD  = pdpdt_pkg::CfgGainD;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgTrimP  = pdpdt_pkg::CfgTrimP;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgTrimI  = pdpdt_pkg::CfgTrimI;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgRamp   = pdpdt_pkg::CfgRamp;
  localparam logic [pdpdt_pkg::CfgIdxW-1:0] CfgNone   = 3'd7;  // unmapped, must be ignored
  localparam longint BaseMax = 64'sd2147483647;
  localparam longint BaseMin = -64'sd2147483648;

  typedef struct packed {
    logic signed [10:0] left;
    logic signed [10:0] right;
    logic               done;
  } speed_cmd_t;

  typedef struct packed {
    logic       hold;  // use the typed value instead of the model
    speed_cmd_t cmd;
  } typed_t;

  typedef enum logic {RowWrite, RowBeat} row_e;

  typedef struct packed {
    row_e                               kind;
    logic [pdpdt_pkg::CfgIdxW-1:0]      idx;
    logic [15:0]                        val;
    logic                               req;
    logic [15:0]                        lpos;
    logic [15:0]                        rpos;
    logic                               pinned;
    speed_cmd_t                         want;
  } plan_row_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [2:0]  cfg_addr_i      = '0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  pid_drive_position_drift_trim u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial forever #2 clk_i = ~clk_i;

  // register mirror
  int tgt_deg  = 0;
  int p_gain   = int'(pdpdt_pkg::GainPRst);
  int i_gain   = int'(pdpdt_pkg::GainIRst);
  int d_gain   = int'(pdpdt_pkg::GainDRst);
  int tp_gain  = int'(pdpdt_pkg::TrimPRst);
  int ti_gain  = int'(pdpdt_pkg::TrimIRst);
  int ramp_rpm = int'(pdpdt_pkg::RampRst);

  // loop state mirror
  longint prior_err = 0;
  longint integ_acc = 0;
  longint trim_acc  = 0;
  longint base_q12  = 0;
  int     hold_left  = 0;
  int     hold_right = 0;
  logic   in_motion  = 1'b0;

  speed_cmd_t speed_q[$];
  typed_t     typed_q[$];
  int         faults = 0;
  logic       calm   = 1'b0;

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Q.12 to rpm: floor after adding one half rounds ties up
  function automatic int q12_to_rpm(input longint q);
    longint r;
    r = (q + 2048) >>> pdpdt_pkg::FracBits;
    return int'(clip(r, pdpdt_pkg::SpdMin, pdpdt_pkg::SpdMax));
  endfunction

  function automatic speed_cmd_t drive_law_step(input logic req, input logic [15:0] lraw,
                                                input logic [15:0] rraw);
    speed_cmd_t res;
    longint tgt, lp, rp, err, der, drift, kd, t, step;
    int lo, ro;
    res = '0;
    tgt = tgt_deg;
    if (req == ReqStart) begin
      integ_acc  = 0;
      trim_acc   = 0;
      base_q12   = 0;
      hold_left  = 0;
      hold_right = 0;
      prior_err  = tgt;
      in_motion  = (tgt != 0);
      res.done   = (tgt == 0);
      return res;
    end
    if (!in_motion) return res;

    lp  = longint'($signed(lraw));
    rp  = longint'($signed(rraw));
    err = tgt - lp;
    // integrate only inside the small band; overshoot there counts as arrival
    if (err != 0 && mag(err) < pdpdt_pkg::IntBand) begin
      if (err > 0) integ_acc = clip(integ_acc + err, pdpdt_pkg::SumMin, pdpdt_pkg::SumMax);
      else err = 0;
    end else begin
      integ_acc = 0;
    end
    der       = err - prior_err;
    prior_err = err;

    if (mag(err) < pdpdt_pkg::PidBand) begin
      kd = (tgt > 0) ? -longint'(d_gain) : longint'(d_gain);
      base_q12 = clip(err * p_gain + integ_acc * i_gain + der * kd, BaseMin, BaseMax);
    end else begin
      step = longint'(ramp_rpm) << pdpdt_pkg::FracBits;
      base_q12 = clip(base_q12 + ((tgt > 0) ? step : -step), BaseMin, BaseMax);
    end

    drift = mag(lp) - mag(rp);
    if (drift != 0) begin
      if (mag(drift) < pdpdt_pkg::TrimBand)
        trim_acc = clip(trim_acc + drift, pdpdt_pkg::SumMin, pdpdt_pkg::SumMax);
      t = drift * tp_gain + trim_acc * ti_gain;
      if (tgt > 0) begin
        lo = q12_to_rpm(base_q12 - t);
        ro = q12_to_rpm(base_q12 + t);
      end else if (tgt < 0) begin
        lo = q12_to_rpm(base_q12 + t);
        ro = q12_to_rpm(base_q12 - t);
      end else begin
        lo = hold_left;
        ro = hold_right;
      end
    end else begin
      lo = q12_to_rpm(base_q12);
      ro = lo;
    end
    hold_left  = lo;
    hold_right = ro;

    if (err == 0) begin
      in_motion = 1'b0;
      res.done  = 1'b1;
    end else begin
      res.left  = 11'(lo);
      res.right = 11'(ro);
    end
    return res;
  endfunction

  // check result beats first, then predict for the input beat of the same edge
  always @(posedge clk_i) begin : monitor
    speed_cmd_t got;
    speed_cmd_t want;
    typed_t     pin;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.left  = m_axis_tdata_o[10:0];
      got.right = m_axis_tdata_o[21:11];
      got.done  = m_axis_tlast_o;
      if (speed_q.size() == 0) begin
        if (faults < 10)
          $display("%0t: result beat with nothing expected: left %0d right %0d done %0b",
                   $realtime, got.left, got.right, got.done);
        faults++;
      end else begin
        want = speed_q.pop_front();
        if (got.left !== want.left || got.right !== want.right ||
            got.done !== want.done || m_axis_tdata_o[23:22] !== 2'b00) begin
          if (faults < 10)
            $display("%0t: mismatch: exp %0d %0d done %0b, got %0d %0d done %0b pad %b",
                     $realtime, want.left, want.right, want.done,
                     got.left, got.right, got.done, m_axis_tdata_o[23:22]);
          faults++;
        end
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      pin  = typed_q.pop_front();
      want = drive_law_step(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[31:16]);
      speed_q.push_back(pin.hold ? pin.cmd : want);
    end
  end

  // result side: stall a random number of cycles per beat
  initial begin : sink
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic send_item(input logic req, input logic [15:0] lpos, input logic [15:0] rpos,
                           input logic hold, input speed_cmd_t cmd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    typed_q.push_back('{hold, cmd});
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {rpos, lpos};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // drop valid and wait until every result beat has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (speed_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [pdpdt_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTarget: tgt_deg  = $signed(val);
      CfgGainP:  p_gain   = int'(val);
      CfgGainI:  i_gain   = int'(val);
      CfgGainD:  d_gain   = int'(val);
      CfgTrimP:  tp_gain  = int'(val);
      CfgTrimI:  ti_gain  = int'(val);
      CfgRamp:   ramp_rpm = int'(val[7:0]);
      default: ;
    endcase
  endtask

  function automatic logic [15:0] draw_gain(input int dflt);
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom);
      default: return 16'(clip(longint'(dflt) * $urandom_range(0, 400) / 100, 0, 65535));
    endcase
  endfunction

  function automatic int deg_clip(input int v);
    return int'(clip(v, -32768, 32767));
  endfunction

  plan_row_t plan_tbl [38] = '{
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h7fff, 16'h8000, 1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b1}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h1234, 16'h4321, 1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowWrite, CfgTarget, 16'd1000, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd0,    16'd0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd0,    16'd5,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd100,  16'd130,  1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd250,  16'd250,  1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd950,  16'd948,  1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd999,  16'd999,  1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd1040, 16'd1030, 1'b1, '{11'sd0, 11'sd0, 1'b1}},
    '{RowWrite, CfgTarget, 16'd8000, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd0,    16'd50,   1'b0, '0},
    '{RowWrite, CfgTarget, 16'd0, ReqTick,  16'h0,    16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  -16'sd50, -16'sd20, 1'b0, '0},
    '{RowWrite, CfgTarget, 16'h8000, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h7fff, 16'h8000, 1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h8000, 16'h7fff, 1'b1, '{11'sd0, 11'sd0, 1'b1}},
    '{RowWrite, CfgGainP,  16'hffff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgGainD,  16'h0000, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgTrimP,  16'hffff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgTrimI,  16'hffff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgRamp,   16'h00ff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgGainI,  16'hffff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowWrite, CfgTarget, 16'd799,  ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd0,    16'd0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd0,    16'd2000, 1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd1598, 16'd0,    1'b0, '0},
    '{RowWrite, CfgTarget, 16'h7fff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqStart, 16'h0,    16'h0,    1'b1, '{11'sd0, 11'sd0, 1'b0}},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h8000, 16'h0,    1'b0, '0},
    '{RowWrite, CfgNone,   16'hffff, ReqTick, 16'h0,  16'h0,    1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'd32700, 16'h7fff, 1'b0, '0},
    '{RowBeat,  CfgTarget, 16'h0, ReqTick,  16'h7fff, 16'h7fff, 1'b1, '{11'sd0, 11'sd0, 1'b1}}
  };

  initial begin : stimulus
    int moved, lpos, rpos, rem, pct, jit, sgn, pick, tgt;
    logic [31:0] noise;
    logic        req;
    moved = 0;
    lpos  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_tbl[i]) begin
      if (plan_tbl[i].kind == RowWrite) begin
        drain();
        write_reg(plan_tbl[i].idx, plan_tbl[i].val);
      end else begin
        send_item(plan_tbl[i].req, plan_tbl[i].lpos, plan_tbl[i].rpos,
                  plan_tbl[i].pinned, plan_tbl[i].want);
      end
    end

    while (moved < 850) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(CfgGainP, draw_gain(int'(pdpdt_pkg::GainPRst)));
      write_reg(CfgGainI, draw_gain(int'(pdpdt_pkg::GainIRst)));
      write_reg(CfgGainD, draw_gain(int'(pdpdt_pkg::GainDRst)));
      write_reg(CfgTrimP, draw_gain(int'(pdpdt_pkg::TrimPRst)));
      write_reg(CfgTrimI, draw_gain(int'(pdpdt_pkg::TrimIRst)));
      pick = $urandom_range(0, 5);
      write_reg(CfgRamp, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd255
                                              : 16'($urandom_range(1, 40)));
      if ($urandom_range(0, 4) == 0) write_reg(CfgNone, 16'($urandom));

      pick = $urandom_range(0, 7);
      sgn  = ($urandom_range(0, 1) != 0) ? 1 : -1;
      case (pick)
        0: tgt = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        1: tgt = 0;
        2: tgt = sgn * int'($urandom_range(1, 150));
        default: tgt = sgn * int'($urandom_range(200, 4000));
      endcase
      write_reg(CfgTarget, 16'(tgt));

      // most phases start a fresh move; the rest retarget one in progress
      if ($urandom_range(0, 5) != 0) begin
        noise = $urandom;
        send_item(ReqStart, noise[15:0], noise[31:16], 1'b0, '0);
        lpos = 0;
        moved++;
      end

      repeat ($urandom_range(15, 60)) begin
        if (!in_motion && $urandom_range(0, 1) == 0) begin
          noise = $urandom;
          send_item(ReqStart, noise[15:0], noise[31:16], 1'b0, '0);
          lpos = 0;
          moved++;
        end else if ($urandom_range(0, 11) == 0) begin
          noise = $urandom;
          req   = 1'($urandom_range(0, 1));
          moved++;
          send_item(req, noise[15:0], noise[31:16], 1'b0, '0);
          if (req == ReqStart) lpos = 0;
        end else begin
          rem = tgt - lpos;
          if (mag(rem) < pdpdt_pkg::IntBand && $urandom_range(0, 5) == 0) begin
            lpos = deg_clip(tgt + int'($urandom_range(1, 99)));
          end else if (mag(rem) < 120 && $urandom_range(0, 2) == 0) begin
            lpos = tgt;
          end else begin
            pct  = $urandom_range(5, 45);
            jit  = $urandom_range(0, 20);
            lpos = deg_clip(lpos + rem * pct / 100 + jit - 10);
          end
          pick = $urandom_range(0, 5);
          sgn  = ($urandom_range(0, 1) != 0) ? 1 : -1;
          case (pick)
            0, 1: rpos = lpos;
            2, 3: rpos = deg_clip(lpos + sgn * int'($urandom_range(1, 19)));
            4:    rpos = deg_clip(lpos + sgn * int'($urandom_range(20, 400)));
            default: rpos = $signed(16'($urandom));
          endcase
          moved++;
          send_item(ReqTick, 16'(lpos), 16'(rpos), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (faults == 0 && speed_q.size() == 0) begin
      $display("pid_drive_position_drift_trim_test: clean");
    end else begin
      $display("pid_drive_position_drift_trim_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("pid_drive_position_drift_trim_test: errors");
    $finish;
  end

endmodule
